/* src/ssps_pkg.sv */
// Shared types, constants, coefficient tables and microcode for the plant step block.
`default_nettype none

package ssps_pkg;

	localparam int SSPS_STATE_WIDTH    = 32;
	localparam int SSPS_COEF_FRAC_BITS = 14;
	localparam int N_STATE             = 6;
	localparam logic [31:0] SCALE_RESET = 32'd21473894;

	// plant coefficients in units of 1/10000
	localparam int A_E4 [N_STATE][N_STATE] = '{
		'{  9652,  -172,    57,   -58,    52,  -251 },
		'{  7732,  1252,  2315,   700,  1282,  7754 },
		'{  8278, -7522,  -956,  3299, -4855,  3915 },
		'{  9948,  2655, -3848,  4212,  3927,  2899 },
		'{  7648, -4165, -4855, -3366,  -986,  7281 },
		'{ 11056,  7587,  1179,   748, -2192,  1491 }
	};
	localparam int B_E4 [N_STATE] = '{ 471, 377, 404, 485, 375, 539 };

	// microcode address map
	localparam int UPC_W = 6;
	localparam logic [UPC_W-1:0] PC_WAIT     = 6'd0;
	localparam logic [UPC_W-1:0] PC_ROW0     = 6'd8;
	localparam logic [UPC_W-1:0] PC_WB_LAST  = 6'd56;
	localparam logic [UPC_W-1:0] PC_BLO      = 6'd57;
	localparam logic [UPC_W-1:0] PC_BHI      = 6'd58;
	localparam logic [UPC_W-1:0] PC_OUT      = 6'd59;
	localparam logic [2:0]       SRC_IN      = 3'd6;
	localparam logic [2:0]       LAST_ROW    = 3'd5;
	localparam logic [2:0]       ROW_TAIL    = 3'd7;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_IN,
		COND_OUT
	} cond_t;

	typedef struct packed {
		logic             mul;     // product of coef(row,src) and operand
		logic             ld;      // acc = product
		logic             add;     // acc += product
		logic             wb;      // round/saturate acc into new state
		logic [2:0]       wb_row;
		logic [2:0]       row;
		logic [2:0]       src;     // 0..5 state, 6 drive input
		logic             commit;  // new state becomes current
		logic             bmul_lo;
		logic             bmul_hi;
		logic             out_ld;
		cond_t            cond;    // hold step until condition met
		logic             jmp;
		logic [UPC_W-1:0] target;
	} ucw_t;

	// signed fixed-point coefficient, nearest, ties away from zero
	function automatic longint quant_coef(input int e4, input int frac);
		longint m;
		longint r;
		m = longint'(e4) * (longint'(1) << frac);
		if (m >= 0)
			r = (m + 5000) / 10000;
		else
			r = -((-m + 5000) / 10000);
		return r;
	endfunction

	// control store: rows sit at pc = 8*(row+1) + k, k = 0..7
	function automatic ucw_t ucode(input logic [UPC_W-1:0] pc);
		ucw_t       w;
		logic [2:0] k;
		logic [2:0] r;
		w        = '0;
		w.cond   = COND_NONE;
		k        = pc[2:0];
		r        = pc[5:3] - 3'd1;
		if (pc == PC_WAIT) begin
			w.cond   = COND_IN;
			w.jmp    = 1'b1;
			w.target = PC_ROW0;
		end else if (pc >= PC_ROW0 && pc < PC_WB_LAST) begin
			w.row = r;
			w.src = (k == ROW_TAIL) ? 3'd0 : k;
			w.mul = (k != ROW_TAIL);
			w.ld  = (k == 3'd1);
			w.add = (k >= 3'd2);
			if (k == 3'd0 && r != 3'd0) begin
				w.wb     = 1'b1;
				w.wb_row = r - 3'd1;
			end
		end else begin
			unique case (pc)
				PC_WB_LAST: begin
					w.wb     = 1'b1;
					w.wb_row = LAST_ROW;
				end
				PC_BLO: begin
					w.commit  = 1'b1;
					w.bmul_lo = 1'b1;
				end
				PC_BHI: begin
					w.bmul_hi = 1'b1;
				end
				PC_OUT: begin
					w.out_ld = 1'b1;
					w.cond   = COND_OUT;
					w.jmp    = 1'b1;
					w.target = PC_WAIT;
				end
				default: begin
					w.jmp    = 1'b1;
					w.target = PC_WAIT;
				end
			endcase
		end
		return w;
	endfunction

endpackage

`default_nettype wire

/* src/state_space_plant_step.sv */
// Top level: microcoded state-space plant step, x = A*x + B*u, with brightness outputs.
//
// Usage
//   Input channel: drive_in (signed Q16.16) with in_valid / in_stall. One word is one
//   sample period. Output channel: plant_out, red_match, green_match with out_valid /
//   out_stall. Every input word yields exactly one output word.
//   Config: cfg_wr_en / cfg_wr_data write brightness_scale (unsigned Q16.16); write only
//   while the block is idle.
// Structure
//   A control store of 60 steps drives one shared MAC unit (state x coef multiplier,
//   product register, accumulator) and one 32x32 brightness multiplier. Each of the six
//   rows has 8 steps (7 products plus accumulate tail), then come write-back, commit, two
//   brightness products and the output load. A new word is accepted only once the
//   sequencer is back in its wait step.
// Stall
//   The result sits in an output register; the next input word is accepted while it waits.
//   If the output register is still full at the output step, the sequencer holds there.
// Reset
//   arst_n clears the state vector to zero, the scale to its reset value, and empties the
//   output register; the sequencer starts waiting for input.
`default_nettype none

module state_space_plant_step
	import ssps_pkg::*;
#(
	parameter int STATE_WIDTH    = SSPS_STATE_WIDTH,
	parameter int COEF_FRAC_BITS = SSPS_COEF_FRAC_BITS
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_wr_en,
	input  wire        [31:0] cfg_wr_data,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire signed [31:0] drive_in,
	output logic              out_valid,
	input  wire               out_stall,
	output logic signed [31:0] plant_out,
	output logic       [15:0] red_match,
	output logic       [14:0] green_match
);

	localparam int SW    = STATE_WIDTH;
	localparam int CW    = COEF_FRAC_BITS + 2;     // |coef| < 2 in Q.F
	localparam int OP_W  = (SW > 32) ? SW : 32;    // operand holds state or drive
	localparam int PW    = OP_W + CW;
	localparam int ACC_W = PW + 3;                 // seven products
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] ST_MAX   = (ACC_W'(1) <<< (SW - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] ST_MIN   = -ST_MAX - ACC_W'(1);
	localparam logic signed [OP_W-1:0]  OUT_MAX  = OP_W'(64'sd2147483647);
	localparam logic signed [OP_W-1:0]  OUT_MIN  = -OUT_MAX - OP_W'(1);

	// coefficient table, column 6 holds B
	logic signed [CW-1:0] coef_tab [N_STATE][N_STATE+1];

	for (genvar gr = 0; gr < N_STATE; gr++) begin : g_row
		for (genvar gc = 0; gc < N_STATE; gc++) begin : g_col
			assign coef_tab[gr][gc] = CW'(quant_coef(A_E4[gr][gc], COEF_FRAC_BITS));
		end
		assign coef_tab[gr][N_STATE] = CW'(quant_coef(B_E4[gr], COEF_FRAC_BITS));
	end

	// sequencer
	logic [UPC_W-1:0] pc_q;
	ucw_t             cw;
	logic             adv;

	// datapath registers
	logic signed [SW-1:0]    x_q  [N_STATE];
	logic signed [SW-1:0]    nx_q [N_STATE];
	logic signed [31:0]      u_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic        [31:0]      scale_q;
	logic        [63:0]      blo_q;
	logic        [63:0]      bhi_q;
	logic                    out_valid_q;
	logic signed [31:0]      plant_out_q;
	logic        [15:0]      red_q;

	// datapath logic
	logic signed [OP_W-1:0]  op_v;
	logic signed [CW-1:0]    coef_v;
	logic signed [PW-1:0]    prod_d;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-1:0] rsh;
	logic signed [SW-1:0]    nx_val;
	logic signed [OP_W-1:0]  x5_ext;
	logic signed [31:0]      x5_sat;
	logic                    x5_pos;
	logic        [63:0]      xu;
	logic        [31:0]      bmul_a;
	logic        [63:0]      bprod;
	logic        [63:0]      bsum;
	logic        [15:0]      red_d;

	assign cw = ucode(pc_q);

	always_comb begin
		unique case (cw.cond)
			COND_NONE: adv = 1'b1;
			COND_IN:   adv = in_valid;
			COND_OUT:  adv = !out_valid_q || !out_stall;
			default:   adv = 1'b1;
		endcase
	end

	assign in_stall = (cw.cond != COND_IN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else if (adv) begin
			pc_q <= cw.jmp ? cw.target : UPC_W'(pc_q + 1'b1);
		end
	end

	// MAC unit: operand select, multiply, then accumulate next step
	assign op_v   = (cw.src == SRC_IN) ? OP_W'(u_q) : OP_W'(x_q[cw.src]);
	assign coef_v = coef_tab[cw.row][cw.src];
	assign prod_d = op_v * coef_v;

	// round half up at the Q16 point, saturate to state width
	always_comb begin
		rnd = acc_q + RND_HALF;
		rsh = rnd >>> COEF_FRAC_BITS;
		if (rsh > ST_MAX)
			nx_val = SW'(ST_MAX);
		else if (rsh < ST_MIN)
			nx_val = SW'(ST_MIN);
		else
			nx_val = SW'(rsh);
	end

	// brightness: floor(x5 * scale / 2^32) from two 32x32 partial products
	assign x5_pos = !nx_q[N_STATE-1][SW-1] && (nx_q[N_STATE-1] != '0);
	assign xu     = 64'($unsigned(nx_q[N_STATE-1]));
	assign bmul_a = cw.bmul_hi ? xu[63:32] : xu[31:0];
	assign bprod  = bmul_a * scale_q;
	assign bsum   = bhi_q + {32'd0, blo_q[63:32]};

	always_comb begin
		if (!x5_pos)
			red_d = '0;
		else if (|bsum[63:16])
			red_d = 16'hFFFF;
		else
			red_d = bsum[15:0];
	end

	always_comb begin
		x5_ext = OP_W'(nx_q[N_STATE-1]);
		if (x5_ext > OUT_MAX)
			x5_sat = 32'(OUT_MAX);
		else if (x5_ext < OUT_MIN)
			x5_sat = 32'(OUT_MIN);
		else
			x5_sat = 32'(x5_ext);
	end

	// state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_STATE; i++)
				x_q[i] <= '0;
			scale_q <= SCALE_RESET;
		end else begin
			if (cw.commit) begin
				for (int i = 0; i < N_STATE; i++)
					x_q[i] <= nx_q[i];
			end
			if (cfg_wr_en)
				scale_q <= cfg_wr_data;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (cw.cond == COND_IN && in_valid)
			u_q <= drive_in;
		if (cw.mul)
			prod_q <= prod_d;
		if (cw.ld)
			acc_q <= ACC_W'(prod_q);
		else if (cw.add)
			acc_q <= acc_q + ACC_W'(prod_q);
		if (cw.wb)
			nx_q[cw.wb_row] <= nx_val;
		if (cw.bmul_lo)
			blo_q <= bprod;
		if (cw.bmul_hi)
			bhi_q <= bprod;
		if (cw.out_ld && adv) begin
			plant_out_q <= x5_sat;
			red_q       <= red_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.out_ld && adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign plant_out   = plant_out_q;
	assign red_match   = red_q;
	assign green_match = red_q[15:1];

	// an accepted word starts the first row
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> pc_q == PC_ROW0)
		else $error("accepted word did not start row 0");

	// brightness products always follow the last row write-back
	a_blo_order: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == PC_BLO |-> $past(pc_q) == PC_WB_LAST)
		else $error("brightness step out of order");

	// output step with a free slot always presents a word next
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == PC_OUT && !out_valid_q |=> out_valid_q)
		else $error("output word not loaded");

	// nonzero brightness only for positive plant output
	a_red_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && red_match != 16'd0 |-> !plant_out[31] && plant_out != 32'sd0)
		else $error("brightness set for nonpositive output");

endmodule

`default_nettype wire

/* tb/sv/plant_step_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the plant step block: models x = A*x + B*u and the brightness, checks each output word.
module plant_step_checker
	import ssps_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_wr_en,
	input  wire        [31:0] cfg_wr_data,
	input  wire               in_valid,
	input  wire               in_stall,
	input  wire signed [31:0] drive_in,
	input  wire               out_valid,
	input  wire               out_stall,
	input  wire signed [31:0] plant_out,
	input  wire        [15:0] red_match,
	input  wire        [14:0] green_match,
	output int                mismatches,
	output int                pending
);

	localparam int SW = SSPS_STATE_WIDTH;
	localparam int CF = SSPS_COEF_FRAC_BITS;

	typedef struct packed {
		logic signed [31:0] plant;
		logic        [15:0] red;
		logic        [14:0] green;
	} plant_word_t;

	longint                coef_a [N_STATE][N_STATE];
	longint                coef_b [N_STATE];
	logic signed [SW-1:0]  plant_x [N_STATE];
	logic        [31:0]    scale;
	plant_word_t           expected_words [$];

	// decimal e-4 constant to signed fixed point, nearest, ties away from zero
	function automatic longint round_coef(input int e4);
		longint m;
		longint mag;
		m   = longint'(e4) * (64'sd1 <<< CF);
		mag = (m < 0) ? -m : m;
		mag = (mag + 5000) / 10000;
		return (m < 0) ? -mag : mag;
	endfunction

	function automatic logic signed [SW-1:0] clamp_state(input longint v);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (SW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi[SW-1:0];
		if (v < lo)
			return lo[SW-1:0];
		return v[SW-1:0];
	endfunction

	// one sample period; all rows read the old state
	function automatic plant_word_t advance_plant(input logic signed [31:0] u);
		int                   i;
		int                   j;
		longint               acc;
		logic signed [SW-1:0] nx [N_STATE];
		logic        [63:0]   prod;
		logic        [15:0]   red;
		plant_word_t          w;
		for (i = 0; i < N_STATE; i++) begin
			acc = coef_b[i] * longint'(u);
			for (j = 0; j < N_STATE; j++)
				acc += coef_a[i][j] * longint'(plant_x[j]);
			// exact sum at 16+CF fraction bits, round half up to 16
			acc   = (acc + (64'sd1 <<< (CF - 1))) >>> CF;
			nx[i] = clamp_state(acc);
		end
		for (i = 0; i < N_STATE; i++)
			plant_x[i] = nx[i];
		if (plant_x[N_STATE-1] <= 0) begin
			red = 16'd0;
		end else begin
			prod = 64'(plant_x[N_STATE-1]) * {32'd0, scale};
			red  = (prod[63:32] > 64'd65535) ? 16'hFFFF : prod[47:32];
		end
		w.plant = plant_x[N_STATE-1][31:0];
		w.red   = red;
		w.green = red[15:1];
		return w;
	endfunction

	initial begin
		int i;
		int j;
		for (i = 0; i < N_STATE; i++) begin
			coef_b[i] = round_coef(B_E4[i]);
			for (j = 0; j < N_STATE; j++)
				coef_a[i][j] = round_coef(A_E4[i][j]);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		plant_word_t want;
		int          bad;
		int          i;
		if (!arst_n) begin
			for (i = 0; i < N_STATE; i++)
				plant_x[i] = '0;
			scale = SCALE_RESET;
			expected_words.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			bad = 0;
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected output word, plant_out %0d", $time, plant_out);
					bad++;
				end else begin
					want = expected_words.pop_front();
					if (plant_out !== want.plant) begin
						$display("%0t: plant_out expected %0d got %0d",
							$time, want.plant, plant_out);
						bad++;
					end
					if (red_match !== want.red) begin
						$display("%0t: red_match expected %0d got %0d",
							$time, want.red, red_match);
						bad++;
					end
					if (green_match !== want.green) begin
						$display("%0t: green_match expected %0d got %0d",
							$time, want.green, green_match);
						bad++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_words.push_back(advance_plant(drive_in));
			if (cfg_wr_en)
				scale = cfg_wr_data;
			mismatches <= mismatches + bad;
			pending    <= expected_words.size();
		end
	end

endmodule

/* tb/sv/tb_state_space_plant_step.sv */
`timescale 1ns / 1ps
// Testbench top for the plant step block: stimulus, output-side stalls, config phases and verdict.
module tb_state_space_plant_step;
	import ssps_pkg::*;

	// words per random config phase; 8 phases plus the directed words give 1940
	localparam int PHASE_WORDS = 240;
	// output hold-off long enough that the block fills and stalls its input
	localparam int LONG_HOLD   = 400;
	// cycles to let pass after the last expected word
	localparam int TAIL_CYCLES = 60;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic        [31:0] cfg_wr_data = '0;
	logic               in_valid    = 1'b0;
	logic signed [31:0] drive_in    = '0;
	logic               out_stall   = 1'b0;
	wire                in_stall;
	wire                out_valid;
	wire  signed [31:0] plant_out;
	wire         [15:0] red_match;
	wire         [14:0] green_match;

	int mismatches;
	int pending;

	// upper bound of the random gap drawn per word on each side; 0 = no idling
	int tx_gap_max  = 0;
	int rx_gap_max  = 0;
	int words_taken = 0;

	logic [31:0] directed_words [20];
	logic [31:0] scale_steps [8];

	state_space_plant_step i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.drive_in    (drive_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.plant_out   (plant_out),
		.red_match   (red_match),
		.green_match (green_match)
	);

	plant_step_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.drive_in    (drive_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.plant_out   (plant_out),
		.red_match   (red_match),
		.green_match (green_match),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop. It lies far beyond the end of a correct run, even with the
	// worst gaps on both sides and the long hold-offs.
	initial begin
		#8_000_000;
		$display("[state_space_plant_step] ERROR");
		$finish;
	end

	// Random drive value. Most words are moderate volts of either sign so the
	// plant output spends time inside the brightness range; the rest are 32-bit
	// noise (every bit toggles), the rails, which saturate the state, and 0, -1 or small values.
	function automatic logic [31:0] pick_drive();
		int          sel;
		logic [31:0] mag;
		logic [31:0] w;
		sel = $urandom_range(0, 9);
		mag = $urandom_range(0, 32'h0014_0000);   // 0..20 V
		case (sel)
			0: w = $urandom();
			1: begin
				case ($urandom_range(0, 3))
					0: w = 32'h7FFF_FFFF;
					1: w = 32'h8000_0000;
					2: w = 32'hFFFF_FFFF;
					default: w = 32'h0000_0000;
				endcase
			end
			2, 3, 4, 5: w = mag;
			6, 7, 8: w = -mag;
			default: w = $urandom_range(0, 511) - 256;
		endcase
		return w;
	endfunction

	// Offer one word: optional idle gap, then hold valid and payload until the
	// block takes it. Entered and left at a falling edge, valid still high, so a
	// zero gap keeps valid up across back-to-back words with one assignment.
	task automatic send_word(input logic [31:0] w);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		drive_in <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Config writes only with the block idle: every accepted word has come out.
	task automatic wait_drained();
		while (pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_scale(input logic [31:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Output side. Per word draw a stall length; when nonzero, stall is raised
	// early, held until the word shows up, then for that many more cycles, so
	// the output register is genuinely backed up. Two words get a very long
	// hold while the sender keeps offering.
	initial begin : receiver
		int hold;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (words_taken == 60 || words_taken == 1100)
				hold = LONG_HOLD;
			else
				hold = $urandom_range(0, rx_gap_max);
			if (hold > 0) begin
				out_stall <= 1'b1;
				@(posedge clk);
				while (!out_valid)
					@(posedge clk);
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			words_taken++;
		end
	end

	initial begin : stimulus
		int ph;
		int k;

		// rails, unit steps, both signs, alternating bit patterns; the runs of
		// max and min drive the state into saturation both ways, which covers
		// brightness clamp at 65535 and zero/negative output giving 0
		directed_words = '{
			32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h0000_0000, 32'h0000_8000, 32'hFFFF_8000, 32'h0003_0000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0000_0000
		};
		// scale settings: both extremes, 1 LSB, unity gain, back to reset
		// value, a coarse gain, and two random ones
		scale_steps = '{
			32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000,
			SCALE_RESET, 32'h0080_0000, $urandom(), $urandom()
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words run at the reset scale, input back to back
		tx_gap_max = 0;
		rx_gap_max = 10;
		for (k = 0; k < 20; k++)
			send_word(directed_words[k]);

		for (ph = 0; ph < 8; ph++) begin
			in_valid <= 1'b0;
			wait_drained();
			write_scale(scale_steps[ph]);
			// rotate idling: both sides, sender only flat out, receiver only
			// flat out, neither idles
			tx_gap_max = (ph % 4 == 1 || ph % 4 == 3) ? 0 : 10;
			rx_gap_max = (ph % 4 == 2 || ph % 4 == 3) ? 0 : 10;
			for (k = 0; k < PHASE_WORDS; k++)
				send_word(pick_drive());
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("[state_space_plant_step] OK");
		else
			$display("[state_space_plant_step] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
src/ssps_pkg.sv
src/state_space_plant_step.sv
tb/sv/plant_step_checker.sv
tb/sv/tb_state_space_plant_step.sv
